// ----- design/evf_pkg.sv -----
// ----------------------------------------------------------------------------
// evf_pkg
// Shared types, constants and helpers for the encoder velocity filter.
// ----------------------------------------------------------------------------
package evf_pkg;

  // Default widths of the position count and timestamp fields.
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF  = 32;

  // Result field width.
  localparam int OUT_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int SCALE_W    = 24;
  localparam int COEFF_W    = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO  = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd111451;
  localparam logic [COEFF_W-1:0] POLE_RST  = 15'd27984;
  localparam logic [COEFF_W-1:0] ZERO_RST  = 15'd2386;

  // One million is split as 15625 * 2^6 for the numerator of the divider.
  localparam int CPS_MUL   = 15625;
  localparam int CPS_SHIFT = 6;
  // Extra numerator bits needed on top of the count width (1e6 < 2^20).
  localparam int NUM_EXTRA = 20;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Rounding constants for the Q23.8 scaling and the Q0.15 filter.
  localparam logic signed [63:0] SCALE_ROUND = 64'sd32768;
  localparam int                 SCALE_SHIFT = 16;
  localparam logic signed [63:0] FILT_ROUND  = 64'sd16384;
  localparam int                 FILT_SHIFT  = 15;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SCALE = 2'd0,
    MUL_POLE  = 2'd1,
    MUL_ZERO  = 2'd2
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     prep;
    logic     div_step;
    logic     cps;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     scale;
    logic     sum;
    logic     commit;
    logic     out_load;
  } evf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dt_zero;
  } evf_status_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [OUT_W-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[OUT_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[OUT_W-1:0];
    end else begin
      r = x[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/evf_ctrl.sv -----
// ----------------------------------------------------------------------------
// evf_ctrl
// Sequencer for the velocity filter: handshakes, divider step count and the
// order of multiply, scale and filter steps.
// ----------------------------------------------------------------------------
module evf_ctrl #(
  parameter int DIV_STEPS = evf_pkg::COUNT_WIDTH_DEF + evf_pkg::NUM_EXTRA
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  evf_pkg::evf_status_t status,
  output evf_pkg::evf_cmd_t    cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_CPS   = 10'b0000001000,
    S_MULV  = 10'b0000010000,
    S_SCALE = 10'b0000100000,
    S_SUM   = 10'b0001000000,
    S_MULZ  = 10'b0010000000,
    S_FILT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             m_tvalid_next;
  logic             accept;
  logic             out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Next state, step counter and datapath commands.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.mul_sel  = evf_pkg::MUL_SCALE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = status.dt_zero ? S_DONE : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = CNT_W'(DIV_STEPS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_CPS;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_CPS: begin
        cmd.cps    = 1'b1;
        state_next = S_MULV;
      end
      S_MULV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = evf_pkg::MUL_SCALE;
        state_next  = S_SCALE;
      end
      S_SCALE: begin
        // The pole product starts while the scaled velocity is taken.
        cmd.scale   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = evf_pkg::MUL_POLE;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_MULZ;
      end
      S_MULZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = evf_pkg::MUL_ZERO;
        state_next  = S_FILT;
      end
      S_FILT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid holds until the transaction completes.
  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ----- design/evf_datapath.sv -----
// ----------------------------------------------------------------------------
// evf_datapath
// Registers, bit-serial divider, shared multiplier and filter arithmetic of
// the velocity filter, driven by commands from the controller.
// ----------------------------------------------------------------------------
module evf_datapath #(
  parameter int COUNT_WIDTH = evf_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = evf_pkg::TIME_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [evf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [evf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [COUNT_WIDTH-1:0]                position_count,
  input  logic [TIME_WIDTH-1:0]                 timestamp_us,
  input  evf_pkg::evf_cmd_t                     cmd,
  output evf_pkg::evf_status_t                  status,
  output logic signed [evf_pkg::OUT_W-1:0]      velocity_cps,
  output logic signed [evf_pkg::OUT_W-1:0]      velocity_rpm,
  output logic                                  time_error
);

  localparam int NUM_W = COUNT_WIDTH + evf_pkg::NUM_EXTRA;
  localparam int OW    = evf_pkg::OUT_W;
  localparam int PW    = evf_pkg::PROD_W;

  // Configuration registers.
  logic [evf_pkg::SCALE_W-1:0] scale_reg;
  logic [evf_pkg::COEFF_W-1:0] pole_reg;
  logic [evf_pkg::COEFF_W-1:0] zero_reg;

  // Filter history.
  logic [COUNT_WIDTH-1:0] last_position;
  logic [TIME_WIDTH-1:0]  last_time;
  logic signed [OW-1:0]   last_cps;
  logic signed [OW-1:0]   filtered_rpm;
  logic signed [OW-1:0]   last_scaled_rpm;

  // Per-item working registers.
  logic [COUNT_WIDTH-1:0] pos_hold;
  logic [TIME_WIDTH-1:0]  ts_hold;
  logic [COUNT_WIDTH-1:0] diff;
  logic [TIME_WIDTH-1:0]  dt;
  logic                   neg;
  logic [NUM_W-1:0]       num;
  logic [TIME_WIDTH-1:0]  rem;
  logic [OW-1:0]          quo;
  logic                   ovf;
  logic signed [OW-1:0]   cps;
  logic signed [OW-1:0]   v_new;
  logic signed [OW:0]     vsum;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   pole_prod;
  logic                   err_flag;

  // Combinational helpers.
  logic [COUNT_WIDTH-1:0]             mag;
  logic [TIME_WIDTH:0]                rem_sh;
  logic                               ge;
  logic                               big;
  logic signed [evf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [evf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [63:0]                 scaled_full;
  logic signed [63:0]                 filt_full;

  assign status.dt_zero = (timestamp_us == last_time);

  // Magnitude of the count difference; the most negative value stays exact.
  assign mag = diff[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - diff) : diff;

  // One restoring division step per cycle.
  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dt});
  assign big    = ovf | quo[OW-1];

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      evf_pkg::MUL_SCALE: begin
        mul_a = evf_pkg::MUL_A_W'(cps);
        mul_b = $signed({1'b0, scale_reg});
      end
      evf_pkg::MUL_POLE: begin
        mul_a = evf_pkg::MUL_A_W'(filtered_rpm);
        mul_b = $signed(evf_pkg::MUL_B_W'(pole_reg));
      end
      evf_pkg::MUL_ZERO: begin
        mul_a = vsum;
        mul_b = $signed(evf_pkg::MUL_B_W'(zero_reg));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounded, floored shifts for the rpm scaling and the filter sum.
  assign scaled_full = (64'(prod) + evf_pkg::SCALE_ROUND) >>> evf_pkg::SCALE_SHIFT;
  assign filt_full   = (64'(pole_prod) + 64'(prod) + evf_pkg::FILT_ROUND)
                       >>> evf_pkg::FILT_SHIFT;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_reg <= evf_pkg::SCALE_RST;
      pole_reg  <= evf_pkg::POLE_RST;
      zero_reg  <= evf_pkg::ZERO_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        evf_pkg::CFG_SCALE: scale_reg <= cfg_wdata[evf_pkg::SCALE_W-1:0];
        evf_pkg::CFG_POLE:  pole_reg  <= cfg_wdata[evf_pkg::COEFF_W-1:0];
        evf_pkg::CFG_ZERO:  zero_reg  <= cfg_wdata[evf_pkg::COEFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // History, updated only when a valid item completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_position   <= '0;
      last_time       <= '0;
      last_cps        <= '0;
      filtered_rpm    <= '0;
      last_scaled_rpm <= '0;
    end else if (cmd.commit) begin
      last_position   <= pos_hold;
      last_time       <= ts_hold;
      last_cps        <= cps;
      filtered_rpm    <= evf_pkg::sat32(filt_full);
      last_scaled_rpm <= v_new;
    end
  end

  // Working registers: capture, divide, scale and filter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_hold <= position_count;
      ts_hold  <= timestamp_us;
      diff     <= position_count - last_position;
      dt       <= timestamp_us - last_time;
      err_flag <= status.dt_zero;
    end
    if (cmd.prep) begin
      neg <= diff[COUNT_WIDTH-1];
      num <= (NUM_W'(mag) * NUM_W'(evf_pkg::CPS_MUL)) << evf_pkg::CPS_SHIFT;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end
    if (cmd.div_step) begin
      num <= num << 1;
      rem <= ge ? TIME_WIDTH'(rem_sh - {1'b0, dt}) : rem_sh[TIME_WIDTH-1:0];
      quo <= {quo[OW-2:0], ge};
      ovf <= ovf | quo[OW-1];
    end
    if (cmd.cps) begin
      if (neg) begin
        cps <= big ? evf_pkg::SAT_MIN[OW-1:0] : $signed(OW'(0) - quo);
      end else begin
        cps <= big ? evf_pkg::SAT_MAX[OW-1:0] : $signed(quo);
      end
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.scale) begin
      v_new <= evf_pkg::sat32(scaled_full);
    end
    if (cmd.sum) begin
      vsum      <= (OW + 1)'(v_new) + (OW + 1)'(last_scaled_rpm);
      pole_prod <= prod;
    end
  end

  // Output register; the history already holds this item's results.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      velocity_cps <= last_cps;
      velocity_rpm <= filtered_rpm;
      time_error   <= err_flag;
    end
  end

endmodule

// ----- design/encoder_velocity_filter.sv -----
// ----------------------------------------------------------------------------
// encoder_velocity_filter
// Encoder velocity in counts per second and low-pass filtered rpm (Q23.8).
// ----------------------------------------------------------------------------
// One item is worked on at a time. A normal item passes through the divider
// setup, the bit-serial restoring divider for count difference times one
// million over the time difference, which runs one quotient bit per cycle
// over COUNT_WIDTH + 20 numerator bits, the scaling and filter steps through
// one shared multiplier and the handover to the output register. An item
// whose timestamp equals the last valid one skips these steps and returns
// the previous results with time_error set. The output register holds a
// finished result until it is taken; a new item is accepted once that result
// has been handed over to it.
module encoder_velocity_filter #(
  parameter int COUNT_WIDTH = evf_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = evf_pkg::TIME_WIDTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  // Configuration writes.
  input  logic                                             cfg_wen,
  input  logic [evf_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [evf_pkg::CFG_DATA_W-1:0]                   cfg_wdata,
  // Input stream.
  input  logic                                             s_tvalid,
  output logic                                             s_tready,
  // position_count, timestamp_us, zero pad
  input  logic [((COUNT_WIDTH + TIME_WIDTH + 7) / 8) * 8-1:0] s_tdata,
  // Output stream.
  output logic                                             m_tvalid,
  input  logic                                             m_tready,
  // velocity_cps, velocity_rpm
  output logic [2*evf_pkg::OUT_W-1:0]                      m_tdata,
  // time_error
  output logic                                             m_tuser
);

  localparam int DIV_STEPS = COUNT_WIDTH + evf_pkg::NUM_EXTRA;

  evf_pkg::evf_cmd_t    cmd;
  evf_pkg::evf_status_t status;

  logic signed [evf_pkg::OUT_W-1:0] velocity_cps;
  logic signed [evf_pkg::OUT_W-1:0] velocity_rpm;

  // Sequencer.
  evf_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  evf_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .position_count (s_tdata[COUNT_WIDTH-1:0]),
    .timestamp_us   (s_tdata[COUNT_WIDTH+TIME_WIDTH-1:COUNT_WIDTH]),
    .cmd            (cmd),
    .status         (status),
    .velocity_cps   (velocity_cps),
    .velocity_rpm   (velocity_rpm),
    .time_error     (m_tuser)
  );

  // Result packing, first field in the low bits.
  assign m_tdata = {velocity_rpm, velocity_cps};

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the encoder velocity filter. Directed tests cover
// the zero time step hold, raw velocity saturation, truncation toward zero,
// count and timestamp wraparound and the coefficient extremes. Random traffic
// then runs under several register settings. A bit-accurate predictor computes
// the expected results, which are compared with every output transaction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int REPORT_MAX  = 10;
  // Index past the register list; writes to it must be ignored.
  localparam logic [evf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One expected output transaction.
  typedef struct packed {
    logic signed [31:0] cps;
    logic signed [31:0] rpm;
    logic               err;
  } velocity_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wen;
  logic [evf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [evf_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           s_tvalid;
  logic                           s_tready;
  // position_count, timestamp_us
  logic [63:0]                    s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  // velocity_cps, velocity_rpm
  logic [63:0]                    m_tdata;
  // time_error
  logic                           m_tuser;

  encoder_velocity_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Predictor copy of the registers and the filter state.
  logic [23:0]        rpm_scale;
  logic [14:0]        pole_w;
  logic [14:0]        zero_w;
  logic [31:0]        prev_count;
  logic [31:0]        prev_stamp;
  logic signed [31:0] filt_rpm;
  logic signed [31:0] prev_rpm_in;
  logic signed [31:0] prev_cps;

  velocity_t expected_velocity[$];

  int cycle_count;
  int mismatch_count;
  int sample_count;
  int hold_count;
  int sat_count;
  int setting_count;
  int burst_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_velocity.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Work out the result of one sample and advance the filter state.
  function automatic velocity_t step_velocity(input logic [31:0] pos, input logic [31:0] ts);
    velocity_t   r;
    logic [31:0] dt;
    logic [31:0] d;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] q1;
    logic [63:0] r1;
    logic [63:0] total;
    longint      cps;
    longint      v;
    longint      acc;
    logic signed [31:0] y;
    dt = ts - prev_stamp;
    // A zero time step returns the previous results and leaves the state alone.
    if (dt == 32'd0) begin
      r.cps = prev_cps;
      r.rpm = filt_rpm;
      r.err = 1'b1;
      return r;
    end
    d   = pos - prev_count;
    neg = d[31];
    mag = neg ? {32'd0, -d} : {32'd0, d};
    // Count difference times one million over dt, truncated toward zero.
    num = mag * 64'd15625;
    q1  = num / {32'd0, dt};
    r1  = num % {32'd0, dt};
    if (q1 >= (64'd1 << 26)) total = 64'd1 << 32;
    else total = q1 * 64'd64 + (r1 * 64'd64) / {32'd0, dt};
    if (neg) cps = (total >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(total);
    else cps = (total > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(total);
    // Scale to rpm in Q23.8, then the first-order low-pass in Q0.15.
    v   = clamp32((cps * longint'({40'd0, rpm_scale}) + 64'sd32768) >>> 16);
    acc = longint'({49'd0, pole_w}) * longint'(filt_rpm)
        + longint'({49'd0, zero_w}) * (v + longint'(prev_rpm_in));
    y   = clamp32((acc + 64'sd16384) >>> 15);
    prev_count  = pos;
    prev_stamp  = ts;
    prev_cps    = cps[31:0];
    prev_rpm_in = v[31:0];
    filt_rpm    = y;
    r.cps = cps[31:0];
    r.rpm = y;
    r.err = 1'b0;
    return r;
  endfunction

  // Send one sample; the sender works in bursts with random gaps between them.
  task automatic send_sample(input logic [31:0] pos, input logic [31:0] ts);
    velocity_t r;
    int        gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {ts, pos};
    do @(posedge clk); while (!s_tready);
    r = step_velocity(pos, ts);
    expected_velocity.push_back(r);
    sample_count++;
    if (r.err) hold_count++;
    else if (r.cps == 32'sh7FFF_FFFF || r.cps == 32'sh8000_0000) sat_count++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Send a sample relative to the last accepted one.
  task automatic send_delta(input logic [31:0] dpos, input logic [31:0] dtime);
    send_sample(prev_count + dpos, prev_stamp + dtime);
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_velocity.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input logic [evf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [evf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      evf_pkg::CFG_SCALE: rpm_scale = data;
      evf_pkg::CFG_POLE:  pole_w    = data[evf_pkg::COEFF_W-1:0];
      evf_pkg::CFG_ZERO:  zero_w    = data[evf_pkg::COEFF_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver: ready with stalls whose pattern steps through three modes in turn.
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        case ((cycle_count / 2500) % 3)
          0: hold = 0;
          1: hold = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : 0;
          default: hold = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 90) : 0;
        endcase
      end
    end
  end

  // Compare each output transaction with the oldest expected result.
  always @(posedge clk) begin
    velocity_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_velocity.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("Unexpected result at cycle %0d: cps %0d rpm %0d err %0b", cycle_count,
                   $signed(m_tdata[31:0]), $signed(m_tdata[63:32]), m_tuser);
      end else begin
        want = expected_velocity.pop_front();
        if (m_tdata[31:0] !== want.cps || m_tdata[63:32] !== want.rpm ||
            m_tuser !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("Result mismatch at cycle %0d: cps %0d/%0d rpm %0d/%0d err %0b/%0b",
                     cycle_count, want.cps, $signed(m_tdata[31:0]), want.rpm,
                     $signed(m_tdata[63:32]), want.err, m_tuser);
        end
      end
    end
  end

  // Hold on a zero time step, from reset and after valid samples.
  task automatic test_zero_step_hold();
    send_sample(32'd0, 32'd0);
    send_sample(32'h8000_0000, 32'hFFFF_FFFF);
    send_delta(32'd0, 32'd0);
    send_delta(32'd12345, 32'd0);
    send_delta(32'd0, 32'd1000);
  endtask

  // Saturation of the raw velocity and truncation toward zero.
  task automatic test_velocity_extremes();
    send_delta(32'h7FFF_FFFF, 32'd1);
    send_delta(32'h8000_0000, 32'd1);
    send_delta(32'd2147, 32'd1);
    send_delta(32'd2148, 32'd1);
    send_delta(-32'sd3, 32'd7);
    send_delta(32'd1, 32'hFFFF_FFFF);
    send_delta(-32'sd1, 32'd1_000_001);
  endtask

  // Wraparound of the position count and of the timestamp.
  task automatic test_wraparound();
    send_sample(32'h7FFF_FFF0, 32'hFFFF_FF00);
    send_sample(32'h8000_0010, 32'h0000_0100);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  // Largest and smallest register values, with masked upper bits.
  task automatic test_coefficient_extremes();
    drain_results();
    write_reg(evf_pkg::CFG_SCALE, 24'hFF_FFFF);
    write_reg(evf_pkg::CFG_POLE, 24'hFF_FFFF);
    write_reg(evf_pkg::CFG_ZERO, 24'hFF_FFFF);
    write_reg(CFG_UNUSED, 24'h00_0001);
    setting_count++;
    repeat (3) send_delta(32'h7FFF_FFFF, 32'd1);
    repeat (3) send_delta(32'h8000_0000, 32'd1);
    drain_results();
    write_reg(evf_pkg::CFG_SCALE, 24'd0);
    write_reg(evf_pkg::CFG_POLE, 24'hFF_8000);
    write_reg(evf_pkg::CFG_ZERO, 24'd0);
    setting_count++;
    send_delta(32'd5000, 32'd100);
    send_delta(-32'sd5000, 32'd3);
    send_delta(32'd0, 32'd0);
    drain_results();
    write_reg(evf_pkg::CFG_SCALE, evf_pkg::SCALE_RST);
    write_reg(evf_pkg::CFG_POLE, {9'd0, evf_pkg::POLE_RST});
    write_reg(evf_pkg::CFG_ZERO, {9'd0, evf_pkg::ZERO_RST});
    setting_count++;
  endtask

  // Mostly well-formed motion with random content, plus holds and noise.
  task automatic test_random_traffic();
    int          phase;
    int          i;
    int          kind;
    int          sel;
    logic [31:0] dpos;
    logic [31:0] dtime;
    logic [14:0] pole;
    for (phase = 0; phase < 5; phase++) begin
      if (phase != 0) begin
        drain_results();
        if ($urandom_range(0, 1) == 0)
          write_reg(evf_pkg::CFG_SCALE, 24'($urandom_range(50000, 200000)));
        else write_reg(evf_pkg::CFG_SCALE, 24'($urandom));
        if ($urandom_range(0, 2) != 0) begin
          pole = 15'($urandom_range(16384, 32767));
          write_reg(evf_pkg::CFG_POLE, {9'($urandom), pole});
          write_reg(evf_pkg::CFG_ZERO, {9'($urandom), 15'((32768 - pole) / 2)});
        end else begin
          write_reg(evf_pkg::CFG_POLE, 24'($urandom));
          write_reg(evf_pkg::CFG_ZERO, 24'($urandom));
        end
        if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED, 24'($urandom));
        setting_count++;
      end
      for (i = 0; i < 110; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          sel = $urandom_range(0, 9);
          if (sel < 6) dtime = $urandom_range(1, 2000);
          else if (sel < 8) dtime = $urandom_range(1, 20);
          else dtime = $urandom;
          sel = $urandom_range(0, 9);
          if (sel < 7) dpos = $urandom_range(0, 4000) - 2000;
          else if (sel < 9) dpos = $urandom_range(0, 2_000_000) - 1_000_000;
          else dpos = $urandom;
          send_delta(dpos, dtime);
        end else if (kind < 80) begin
          send_sample($urandom, prev_stamp);
        end else begin
          send_sample($urandom, $urandom);
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_index      = evf_pkg::CFG_SCALE;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    rpm_scale      = evf_pkg::SCALE_RST;
    pole_w         = evf_pkg::POLE_RST;
    zero_w         = evf_pkg::ZERO_RST;
    prev_count     = '0;
    prev_stamp     = '0;
    filt_rpm       = '0;
    prev_rpm_in    = '0;
    prev_cps       = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    sample_count   = 0;
    hold_count     = 0;
    sat_count      = 0;
    setting_count  = 1;
    burst_left     = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_step_hold();
    test_velocity_extremes();
    test_wraparound();
    test_coefficient_extremes();
    test_random_traffic();

    drain_results();
    repeat (70) @(posedge clk);
    $display("Checked %0d samples under %0d register settings.", sample_count, setting_count);
    $display("Zero time steps held: %0d, saturated raw velocities: %0d.", hold_count,
             sat_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
